// ===== rtl/lfida_pkg.sv =====
`default_nettype none

package lfida_pkg;

    // Operation codes carried in the command
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_ALLOCATED    = 2'd0;
    localparam logic [1:0] ST_RELEASED     = 2'd1;
    localparam logic [1:0] ST_NONE_FREE    = 2'd2;
    localparam logic [1:0] ST_OUT_OF_RANGE = 2'd3;

    // Register indexes on the configuration port
    localparam logic REG_BASE_ID  = 1'b0;
    localparam logic REG_ID_COUNT = 1'b1;

    // Reset values of the configuration registers
    localparam logic [12:0] BASE_ID_RST  = 13'd300;
    localparam logic [13:0] ID_COUNT_RST = 14'd4701;

    typedef struct packed {
        logic        opcode;
        logic [13:0] id_in;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [13:0] id_out;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/lfida_pick.sv =====
`default_nettype none

// Lowest free bit of one bitmap word, limited to the first i_remain bits.
module lfida_pick
    import lfida_pkg::*;
#(
    parameter int WORD_BITS = 64,
    parameter int RW        = 14,
    parameter int IW        = $clog2(WORD_BITS)
) (
    input  wire logic [WORD_BITS-1:0] i_word,
    input  wire logic [RW-1:0]        i_remain,
    output logic                      o_found,
    output logic [IW-1:0]             o_index,
    output logic [WORD_BITS-1:0]      o_onehot
);

    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] free_bits;

    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            mask[b] = (RW'(b) < i_remain);
        end
    end

    assign free_bits = ~i_word & mask;
    // isolate the lowest set bit of the free map
    assign o_onehot  = free_bits & (~free_bits + WORD_BITS'(1));
    assign o_found   = |free_bits;

    always_comb begin
        o_index = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            if (o_onehot[b]) begin
                o_index = o_index | IW'(b);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lowest_free_id_allocator.sv =====
// Steps: an allocate reads bitmap words from word 0 upward and stops at the first word with a
// free bit, or at the last word in play; a release advances from word 0 to the word holding its
// offset and clears the bit there; an out-of-range release or an allocate on an empty pool is
// answered at once, with no scan. One bitmap word is read and tested per cycle while scanning;
// one transaction at a time, the next taken at the edge that takes the result.
// Reset: a clearing pass writes every word free, all NUM_WORDS of them (128 at defaults).
`default_nettype none

module lowest_free_id_allocator
    import lfida_pkg::*;
#(
    parameter int POOL_SIZE = 8192,
    parameter int WORD_BITS = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // command channel
    input  wire logic        start,
    output logic             busy,
    input  wire t_cmd        i_cmd,

    // result channel: one-cycle strobe, no back-pressure
    output logic             o_valid,
    output t_result          o_result,

    // APB-style configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // ------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------
    localparam int NUM_WORDS = POOL_SIZE / WORD_BITS;
    localparam int MAP_BITS  = NUM_WORDS * WORD_BITS;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int IW        = $clog2(WORD_BITS);
    localparam int OFF_W     = $clog2(POOL_SIZE + 1);
    localparam int CW        = (OFF_W > 14) ? OFF_W : 14;
    localparam int SW        = OFF_W + 1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN
    } t_state;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state               r_state;
    logic [AW-1:0]        r_word;       // bitmap word under test
    logic [OFF_W-1:0]     r_word_base;  // offset of bit 0 of r_word
    logic                 r_op;
    logic [OFF_W-1:0]     r_rel;        // offset being released
    logic                 r_valid;
    t_result              r_result;
    logic [12:0]          r_base_id;
    logic [13:0]          r_id_count;
    logic [WORD_BITS-1:0] r_rdata;

    // bitmap store, 1 = busy
    logic [WORD_BITS-1:0] r_map [NUM_WORDS];

    // ------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------
    logic [OFF_W-1:0]     limit;
    logic [13:0]          diff;
    logic                 in_range;
    logic [AW-1:0]        rd_addr;
    logic                 last_word;
    logic                 alloc_end;
    logic                 rel_hit;
    logic [IW-1:0]        rel_bit;
    logic [OFF_W-1:0]     remain;
    logic                 pick_found;
    logic [IW-1:0]        pick_index;
    logic [WORD_BITS-1:0] pick_onehot;
    logic [13:0]          alloc_id;
    logic                 mem_we;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 cfg_wr;

    // Clamp the live count to the bits the map really holds
    assign limit = (CW'(r_id_count) > CW'(MAP_BITS)) ? OFF_W'(MAP_BITS)
                                                     : OFF_W'(r_id_count);

    // Range check for a release, done at accept
    assign diff     = i_cmd.id_in - 14'(r_base_id);
    assign in_range = (i_cmd.id_in >= 14'(r_base_id)) && (CW'(diff) < CW'(limit));

    assign last_word = (r_word == AW'(NUM_WORDS - 1));
    assign alloc_end = last_word ||
                       ((SW'(r_word_base) + SW'(WORD_BITS)) >= SW'(limit));
    assign rel_hit   = SW'(r_rel) < (SW'(r_word_base) + SW'(WORD_BITS));
    assign rel_bit   = IW'(r_rel - r_word_base);
    assign remain    = limit - r_word_base;
    assign alloc_id  = 14'(CW'(r_base_id) + CW'(r_word_base) + CW'(pick_index));

    // Prefetch: word 0 on accept, the following word while scanning
    assign rd_addr = (r_state == S_IDLE) ? '0 : AW'(r_word + AW'(1));

    lfida_pick #(
        .WORD_BITS (WORD_BITS),
        .RW        (OFF_W),
        .IW        (IW)
    ) u_pick (
        .i_word   (r_rdata),
        .i_remain (remain),
        .o_found  (pick_found),
        .o_index  (pick_index),
        .o_onehot (pick_onehot)
    );

    // Bitmap write: clearing pass, set on allocate, clear on release
    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = r_rdata;
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
            end
            S_SCAN: begin
                if (r_op == OP_ALLOC) begin
                    mem_we    = pick_found;
                    mem_wdata = r_rdata | pick_onehot;
                end else begin
                    mem_we    = rel_hit;
                    mem_wdata = r_rdata & ~(WORD_BITS'(1) << rel_bit);
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_map[r_word] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_map[rd_addr];
    end

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[2])
            REG_BASE_ID:  prdata = 32'(r_base_id);
            REG_ID_COUNT: prdata = 32'(r_id_count);
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: state, counters and registered result
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_word      <= '0;
            r_word_base <= '0;
            r_valid     <= 1'b0;
            r_base_id   <= BASE_ID_RST;
            r_id_count  <= ID_COUNT_RST;
        end else begin
            r_valid <= 1'b0;

            // user writes only while idle, unenforced; takes effect on the next transaction
            if (cfg_wr) begin
                if (paddr[2] == REG_BASE_ID) begin
                    r_base_id <= pwdata[12:0];
                end else begin
                    r_id_count <= pwdata[13:0];
                end
            end

            unique case (r_state)
                S_CLEAR: begin
                    // sweep the map free, one word a cycle
                    r_word <= AW'(r_word + AW'(1));
                    if (last_word) begin
                        r_word  <= '0;
                        r_state <= S_IDLE;
                    end
                end

                S_IDLE: begin
                    if (start) begin
                        r_op        <= i_cmd.opcode;
                        r_rel       <= OFF_W'(CW'(diff));
                        r_word      <= '0;
                        r_word_base <= '0;
                        if (i_cmd.opcode == OP_RELEASE && !in_range) begin
                            // answer at once, map untouched
                            r_valid  <= 1'b1;
                            r_result <= '{status: ST_OUT_OF_RANGE, id_out: '0};
                        end else if (i_cmd.opcode == OP_ALLOC && limit == '0) begin
                            r_valid  <= 1'b1;
                            r_result <= '{status: ST_NONE_FREE, id_out: '0};
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end

                S_SCAN: begin
                    if (r_op == OP_ALLOC) begin
                        if (pick_found) begin
                            r_valid  <= 1'b1;
                            r_result <= '{status: ST_ALLOCATED, id_out: alloc_id};
                            r_state  <= S_IDLE;
                        end else if (alloc_end) begin
                            r_valid  <= 1'b1;
                            r_result <= '{status: ST_NONE_FREE, id_out: '0};
                            r_state  <= S_IDLE;
                        end else begin
                            r_word      <= AW'(r_word + AW'(1));
                            r_word_base <= OFF_W'(SW'(r_word_base) + SW'(WORD_BITS));
                        end
                    end else begin
                        // advance to the word holding the offset, then drop its bit
                        if (rel_hit || last_word) begin
                            r_valid  <= 1'b1;
                            r_result <= '{status: ST_RELEASED, id_out: '0};
                            r_state  <= S_IDLE;
                        end else begin
                            r_word      <= AW'(r_word + AW'(1));
                            r_word_base <= OFF_W'(SW'(r_word_base) + SW'(WORD_BITS));
                        end
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== rtl/lfida_chk.sv =====
`default_nettype none

module lfida_chk
    import lfida_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    start,
    input  wire logic    busy,
    input  wire t_cmd    i_cmd,
    input  wire logic    o_valid,
    input  wire t_result o_result,
    input  wire logic    pready
);

    // a result never shows while a transaction is still at work
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // identifier only carried with an allocation
    a_id_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status != ST_ALLOCATED) |-> (o_result.id_out == '0))
        else $error("non-zero identifier on a non-allocate result");

    // a release either starts a scan or is refused as out of range at once
    a_release_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd.opcode == OP_RELEASE) |=>
            (busy || (o_valid && o_result.status == ST_OUT_OF_RANGE)))
        else $error("release neither scanned nor refused");

    // an allocate either starts a scan or finds the pool empty at once
    a_alloc_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd.opcode == OP_ALLOC) |=>
            (busy || (o_valid && o_result.status == ST_NONE_FREE)))
        else $error("allocate neither scanned nor refused");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("configuration port stalled");

endmodule

bind lowest_free_id_allocator lfida_chk u_lfida_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_cmd    (i_cmd),
    .o_valid  (o_valid),
    .o_result (o_result),
    .pready   (pready)
);

`default_nettype wire

// ===== verif/lowest_free_id_allocator_tb.sv =====
`default_nettype none

module lowest_free_id_allocator_tb;
    import lfida_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Block sizes at their defaults
    localparam int POOL_IDS  = 8192;
    localparam int WORD_BITS = 64;
    localparam int NUM_WORDS = POOL_IDS / WORD_BITS;

    // Cycles without any transaction before the run is abandoned. The slowest
    // correct gap is the clearing pass or a full bitmap scan plus a sender gap.
    localparam int STALL_LIMIT = 2000;

    localparam int ITEMS_PER_PHASE = 150;
    localparam int NUM_PHASES      = 8;

    // One row of the directed table: a command, a command with its result
    // written out by hand, or a register write
    typedef enum logic [1:0] {
        ROW_CMD,
        ROW_KNOWN,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        t_cmd        cmd;
        t_result     known;
        logic        reg_idx;
        logic [31:0] reg_val;
    } t_row;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    logic        busy;
    t_cmd        i_cmd   = '0;
    logic        o_valid;
    t_result     o_result;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // Shadow of the block: busy bit per pool offset and the two registers
    bit          id_taken [POOL_IDS];
    logic [12:0] cfg_base  = BASE_ID_RST;
    logic [13:0] cfg_count = ID_COUNT_RST;

    t_result     expected_results [$];
    logic [13:0] held_ids [$];
    t_row        directed_rows [$];
    int          mismatch_count = 0;
    int          stall_cycles   = 0;

    lowest_free_id_allocator dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_valid  (o_valid),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Number of identifiers actually in play: a count above the pool is clipped
    function automatic int unsigned live_count();
        return (cfg_count > POOL_IDS) ? POOL_IDS : int'(cfg_count);
    endfunction

    // Work out the result of one accepted command and advance the shadow bitmap
    function automatic t_result predict_outcome(t_cmd c);
        t_result     r;
        int unsigned lim;
        int unsigned id;
        int unsigned base;
        lim      = live_count();
        id       = c.id_in;
        base     = cfg_base;
        r.status = ST_NONE_FREE;
        r.id_out = '0;
        if (c.opcode == OP_ALLOC) begin
            // lowest free offset wins
            for (int unsigned off = 0; off < lim; off++) begin
                if (!id_taken[off]) begin
                    id_taken[off] = 1'b1;
                    r.status      = ST_ALLOCATED;
                    r.id_out      = 14'(base + off);
                    break;
                end
            end
        end else if (id >= base && (id - base) < lim) begin
            // releasing an already free identifier is not an error
            id_taken[id - base] = 1'b0;
            r.status            = ST_RELEASED;
        end else begin
            r.status = ST_OUT_OF_RANGE;
        end
        return r;
    endfunction

    function automatic t_row cmd_row(logic op, logic [13:0] id);
        t_row r;
        r        = '0;
        r.kind   = ROW_CMD;
        r.cmd    = '{opcode: op, id_in: id};
        return r;
    endfunction

    function automatic t_row known_row(logic op, logic [13:0] id, logic [1:0] st,
                                       logic [13:0] id_out);
        t_row r;
        r       = cmd_row(op, id);
        r.kind  = ROW_KNOWN;
        r.known = '{status: st, id_out: id_out};
        return r;
    endfunction

    function automatic t_row cfg_row(logic idx, logic [31:0] val);
        t_row r;
        r         = '0;
        r.kind    = ROW_CFG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // Append one row to the directed table
    function automatic void add_row(t_row r);
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    // Present a command and hold it until the block takes it. Start is left
    // high so that back-to-back transactions need no second assignment.
    task automatic issue_cmd(t_cmd c, bit use_known, t_result known);
        t_result r;
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        r = predict_outcome(c);
        if (r.status == ST_ALLOCATED) held_ids.insert(held_ids.size(), r.id_out);
        expected_results.insert(expected_results.size(), use_known ? known : r);
    endtask

    // Drop start and hold off until every outstanding result has arrived
    task automatic wait_idle();
        start <= 1'b0;
        while (expected_results.size() != 0 || busy) @(posedge i_clk);
    endtask

    // Setup phase then access phase; the register takes the value at the edge
    // where the access completes. The port then returns to idle.
    task automatic write_reg(logic idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == REG_BASE_ID) cfg_base = val[12:0];
        else cfg_count = val[13:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly well-formed traffic: allocations, releases of identifiers that
    // were handed out, in-range releases at random, and some plain noise
    function automatic t_cmd random_cmd();
        t_cmd        c;
        int unsigned lim;
        int unsigned roll;
        int unsigned pick;
        lim     = live_count();
        c.id_in = 14'($urandom);
        roll    = $urandom_range(99);
        if (roll < 55) begin
            c.opcode = OP_ALLOC;
        end else begin
            c.opcode = OP_RELEASE;
            if (roll < 82 && held_ids.size() != 0) begin
                pick    = $urandom_range(held_ids.size() - 1);
                c.id_in = held_ids[pick];
                held_ids.delete(pick);
            end else if (roll < 94 && lim != 0) begin
                c.id_in = 14'(int'(cfg_base) + $urandom_range(lim - 1));
            end
        end
        return c;
    endfunction

    task automatic run_phase(int idle_pct);
        t_result none;
        none = '0;
        for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            issue_cmd(random_cmd(), 1'b0, none);
            if ($urandom_range(59) == 0) begin
                // let the block drain completely now and then
                wait_idle();
            end else if ($urandom_range(99) < idle_pct) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    endtask

    // Compare each result strobe against the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: status %0d id_out %0d",
                       o_result.status, o_result.id_out);
                mismatch_count = mismatch_count + 1;
            end else begin
                want = expected_results.pop_front();
                if (o_result.status !== want.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want.status, o_result.status);
                    mismatch_count = mismatch_count + 1;
                end
                if (o_result.id_out !== want.id_out) begin
                    $error("id_out mismatch: expected %0d, actual %0d",
                           want.id_out, o_result.id_out);
                    mismatch_count = mismatch_count + 1;
                end
            end
        end
    end

    // Abandon the run if no transaction of any kind moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid
            || (psel && penable && pwrite && pready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int          idle_pct;
        logic [12:0] ph_base;
        logic [31:0] ph_count;

        // Directed table, starting from the reset configuration (base 300,
        // 4701 identifiers, every identifier free)
        add_row(known_row(OP_ALLOC, 14'd0, ST_ALLOCATED, 14'd300));
        add_row(known_row(OP_ALLOC, 14'd0, ST_ALLOCATED, 14'd301));
        add_row(known_row(OP_RELEASE, 14'd300, ST_RELEASED, 14'd0));
        // second release of the same identifier is accepted silently
        add_row(known_row(OP_RELEASE, 14'd300, ST_RELEASED, 14'd0));
        add_row(known_row(OP_ALLOC, 14'd0, ST_ALLOCATED, 14'd300));
        // just below and just above the range, then the last identifier
        add_row(known_row(OP_RELEASE, 14'd299, ST_OUT_OF_RANGE, 14'd0));
        add_row(known_row(OP_RELEASE, 14'd5001, ST_OUT_OF_RANGE, 14'd0));
        add_row(known_row(OP_RELEASE, 14'd5000, ST_RELEASED, 14'd0));
        add_row(known_row(OP_RELEASE, 14'd0, ST_OUT_OF_RANGE, 14'd0));
        add_row(known_row(OP_RELEASE, 14'h3FFF, ST_OUT_OF_RANGE, 14'd0));
        // reconfigure with the bitmap in use: offsets 0 and 1 stay busy
        add_row(cfg_row(REG_BASE_ID, 32'd0));
        add_row(cfg_row(REG_ID_COUNT, 32'd1));
        add_row(known_row(OP_ALLOC, 14'd0, ST_NONE_FREE, 14'd0));
        // offset 1 lies beyond the count, so its busy bit is out of reach
        add_row(known_row(OP_RELEASE, 14'd1, ST_OUT_OF_RANGE, 14'd0));
        add_row(known_row(OP_RELEASE, 14'd0, ST_RELEASED, 14'd0));
        add_row(known_row(OP_ALLOC, 14'd0, ST_ALLOCATED, 14'd0));
        // empty pool
        add_row(cfg_row(REG_ID_COUNT, 32'd0));
        add_row(known_row(OP_ALLOC, 14'd0, ST_NONE_FREE, 14'd0));
        add_row(known_row(OP_RELEASE, 14'd0, ST_OUT_OF_RANGE, 14'd0));
        // all-ones writes: upper data bits dropped, count clipped to the pool
        add_row(cfg_row(REG_BASE_ID, 32'hFFFF_FFFF));
        add_row(cfg_row(REG_ID_COUNT, 32'hFFFF_FFFF));
        add_row(cmd_row(OP_ALLOC, 14'd0));
        add_row(known_row(OP_RELEASE, 14'd16382, ST_RELEASED, 14'd0));
        add_row(known_row(OP_RELEASE, 14'h3FFF, ST_OUT_OF_RANGE, 14'd0));
        add_row(known_row(OP_RELEASE, 14'd8190, ST_OUT_OF_RANGE, 14'd0));
        add_row(cfg_row(REG_ID_COUNT, 32'd8192));
        // allocate ignores whatever sits in id_in
        add_row(cmd_row(OP_ALLOC, 14'h3FFF));
        add_row(cmd_row(OP_RELEASE, 14'd8191));

        // Hold reset, then release it; the clearing pass shows up as busy
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[n]) begin
            if (directed_rows[n].kind == ROW_CFG) begin
                wait_idle();
                write_reg(directed_rows[n].reg_idx, directed_rows[n].reg_val);
            end else begin
                issue_cmd(directed_rows[n].cmd, directed_rows[n].kind == ROW_KNOWN,
                          directed_rows[n].known);
            end
        end

        // Random phases: each reconfigures the idle block, keeps the bitmap
        // it inherits, and sets its own sender idling
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            ph_base  = 13'($urandom);
            ph_count = $urandom_range(1, 200);
            case (ph % 3)
                0: idle_pct = 0;
                1: idle_pct = 50;
                default: idle_pct = 30;
            endcase
            case (ph)
                0: begin
                    ph_base  = '0;
                    ph_count = WORD_BITS;
                end
                1: begin
                    ph_base  = 13'h1FFF;
                    ph_count = POOL_IDS;
                end
                3: ph_count = 32'h3FFF;
                4: ph_count = $urandom_range(WORD_BITS + 1, 2 * WORD_BITS + 2);
                5: begin
                    ph_base  = '0;
                    ph_count = 1;
                end
                6: ph_count = $urandom_range(1, POOL_IDS);
                default: ;
            endcase
            wait_idle();
            write_reg(REG_BASE_ID, {19'd0, ph_base});
            write_reg(REG_ID_COUNT, ph_count);
            run_phase(idle_pct);
        end

        // Drain, then watch a full scan time for anything stray
        wait_idle();
        repeat (NUM_WORDS + 2) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/lfida_pkg.sv
rtl/lfida_pick.sv
rtl/lowest_free_id_allocator.sv
rtl/lfida_chk.sv
verif/lowest_free_id_allocator_tb.sv
